FILE: rtl/pattern_run_length_decoder_core_defines.svh
// Assertion macros used by the checker file of the run-length decoder.
// No dependencies; included by bare file name.
`ifndef PATTERN_RUN_LENGTH_DECODER_CORE_DEFINES_SVH
`define PATTERN_RUN_LENGTH_DECODER_CORE_DEFINES_SVH

// Plain property under clock and active-low reset.
`define PRLD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal is unchanged in the cycle after the condition is seen.
`define PRLD_ASSERT_HOLD(name, clk, rst_n, cond, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    cond |=> $stable(sig)) else $error(msg);

`endif

FILE: rtl/prld_pkg.sv
// Package for the pattern run-length decoder: widths and the start command
// passed from the byte parser to the copy emitter. No dependencies.
`default_nettype none

package prld_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned NibbleW    = 4;
  localparam int unsigned StoreDepth = 15;
  localparam int unsigned PatternW   = StoreDepth * ByteW;
  localparam int unsigned LowW       = 64;
  localparam int unsigned HighW      = PatternW - LowW;

  typedef logic [NibbleW-1:0] nibble_t;

  // Command from parser to emitter, valid for one cycle.
  typedef struct packed {
    logic    go;
    logic    eom;
    nibble_t count;
  } start_t;

endpackage

`default_nettype wire

FILE: rtl/prld_store.sv
// Pattern byte store: 15 byte registers, one write port, packed read-out
// with bytes at or beyond the run length forced to zero. Uses prld_pkg.
`default_nettype none

module prld_store (
  input  wire logic                               clk_i,
  input  wire logic                               wr_en_i,
  input  wire prld_pkg::nibble_t                  wr_idx_i,
  input  wire logic [prld_pkg::ByteW-1:0]         wr_byte_i,
  input  wire prld_pkg::nibble_t                  len_i,
  output logic      [prld_pkg::PatternW-1:0]      pattern_o
);

  logic [prld_pkg::ByteW-1:0] store_q [prld_pkg::StoreDepth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[wr_idx_i] <= wr_byte_i;
    end
  end

  always_comb begin
    for (int i = 0; i < int'(prld_pkg::StoreDepth); i++) begin
      pattern_o[i*prld_pkg::ByteW +: prld_pkg::ByteW] =
          (prld_pkg::nibble_t'(i) < len_i) ? store_q[i] : '0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/prld_emit.sv
// Copy emitter: a copy counter with one shared decrement and compare,
// feeding a registered output stage. Uses prld_pkg.
`default_nettype none

module prld_emit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire prld_pkg::start_t                   start_i,
  input  wire logic [prld_pkg::PatternW-1:0]      pattern_i,
  input  wire prld_pkg::nibble_t                  len_i,
  input  wire logic                               out_stall_i,
  output logic                                    busy_o,
  output logic                                    out_valid_o,
  output logic      [prld_pkg::LowW-1:0]          pattern_low_o,
  output logic      [prld_pkg::HighW-1:0]         pattern_high_o,
  output logic      [prld_pkg::NibbleW-1:0]       pattern_length_o,
  output logic                                    last_copy_o,
  output logic                                    end_of_message_o
);

  prld_pkg::nibble_t cnt_q;
  logic              eom_q;
  logic              out_valid_q;
  logic              load;

  // next copy goes out when copies remain and the output stage is free
  assign load   = (cnt_q != '0) && (!out_valid_q || !out_stall_i);
  assign busy_o = (cnt_q != '0) || out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      eom_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (start_i.go) begin
      cnt_q <= start_i.count;
      eom_q <= start_i.eom;
    end else if (load) begin
      cnt_q       <= cnt_q - prld_pkg::nibble_t'(1);
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (eom_q) begin
        pattern_low_o    <= '0;
        pattern_high_o   <= '0;
        pattern_length_o <= '0;
        last_copy_o      <= 1'b0;
        end_of_message_o <= 1'b1;
      end else begin
        pattern_low_o    <= pattern_i[prld_pkg::LowW-1:0];
        pattern_high_o   <= pattern_i[prld_pkg::PatternW-1:prld_pkg::LowW];
        pattern_length_o <= len_i;
        last_copy_o      <= (cnt_q == prld_pkg::nibble_t'(1));
        end_of_message_o <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/pattern_run_length_decoder_core.sv
// Top level of the pattern run-length decoder: header/fill parser, pattern
// store and copy emitter. Uses prld_pkg, prld_store, prld_emit.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o   | in_byte_i
//  out     | output    | out_valid_o / out_stall_i | pattern_low_o, pattern_high_o,
//          |           |                           | pattern_length_o, last_copy_o,
//          |           |                           | end_of_message_o
//
// The byte that completes a pattern, or a zero header, starts the copy counter;
// it then puts out one copy per cycle while the output is not stalled (count
// copies, or one end marker) and the input stalls until the last copy has
// left the output register. Reset is asynchronous, active low, and clears
// control state only.
`default_nettype none

module pattern_run_length_decoder_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [prld_pkg::ByteW-1:0]         in_byte_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [prld_pkg::LowW-1:0]          pattern_low_o,
  output logic      [prld_pkg::HighW-1:0]         pattern_high_o,
  output logic      [prld_pkg::NibbleW-1:0]       pattern_length_o,
  output logic                                    last_copy_o,
  output logic                                    end_of_message_o
);

  typedef enum logic {
    ST_HEADER,
    ST_FILL
  } state_e;

  state_e            state_q, state_d;
  prld_pkg::nibble_t len_q, len_d;
  prld_pkg::nibble_t rep_q, rep_d;
  prld_pkg::nibble_t fill_q, fill_d;
  prld_pkg::nibble_t fill_inc;
  prld_pkg::nibble_t hdr_len, hdr_cnt;
  prld_pkg::start_t  start;
  logic [prld_pkg::PatternW-1:0] pattern;
  logic              busy;
  logic              accept;
  logic              wr_en;

  assign accept   = in_valid_i && !busy;
  assign hdr_len  = in_byte_i[prld_pkg::ByteW-1:prld_pkg::NibbleW];
  assign hdr_cnt  = in_byte_i[prld_pkg::NibbleW-1:0];
  assign fill_inc = fill_q + prld_pkg::nibble_t'(1);
  assign wr_en    = accept && (state_q == ST_FILL);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    rep_d       = rep_q;
    fill_d      = fill_q;
    start.go    = 1'b0;
    start.eom   = 1'b0;
    start.count = '0;
    if (accept) begin
      case (state_q)
        ST_HEADER: begin
          if (in_byte_i == '0) begin
            start.go    = 1'b1;
            start.eom   = 1'b1;
            start.count = prld_pkg::nibble_t'(1);
          end else if (hdr_len != '0) begin
            len_d   = hdr_len;
            rep_d   = hdr_cnt;
            fill_d  = '0;
            state_d = ST_FILL;
          end
        end
        ST_FILL: begin
          fill_d = fill_inc;
          if (fill_inc == len_q) begin
            // zero repeat count loads an empty counter: nothing is emitted
            start.go    = 1'b1;
            start.count = rep_q;
            fill_d      = '0;
            state_d     = ST_HEADER;
          end
        end
        default: state_d = ST_HEADER;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER;
      len_q   <= '0;
      rep_q   <= '0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      rep_q   <= rep_d;
      fill_q  <= fill_d;
    end
  end

  prld_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_idx_i  (fill_q),
    .wr_byte_i (in_byte_i),
    .len_i     (len_q),
    .pattern_o (pattern)
  );

  prld_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .pattern_i        (pattern),
    .len_i            (len_q),
    .out_stall_i      (out_stall_i),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .pattern_low_o    (pattern_low_o),
    .pattern_high_o   (pattern_high_o),
    .pattern_length_o (pattern_length_o),
    .last_copy_o      (last_copy_o),
    .end_of_message_o (end_of_message_o)
  );

  assign in_stall_o = busy;

endmodule

`default_nettype wire

FILE: rtl/prld_checker.sv
// Port-level checker for the pattern run-length decoder, bound to the top.
// Uses the macros of pattern_run_length_decoder_core_defines.svh.
`default_nettype none
`include "pattern_run_length_decoder_core_defines.svh"

module prld_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         in_stall_o,
  input wire logic         out_valid_o,
  input wire logic         out_stall_i,
  input wire logic [63:0]  pattern_low_o,
  input wire logic [55:0]  pattern_high_o,
  input wire logic [3:0]   pattern_length_o,
  input wire logic         last_copy_o,
  input wire logic         end_of_message_o
);

  `PRLD_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, pattern_low_o, "stalled output item changed")
  `PRLD_ASSERT(a_in_blocked, clk_i, rst_ni, out_valid_o |-> in_stall_o, "input taken while a copy waits")
  `PRLD_ASSERT(a_eom_empty, clk_i, rst_ni, (out_valid_o && end_of_message_o) |-> (pattern_length_o == 4'd0 && !last_copy_o && pattern_low_o == 64'd0 && pattern_high_o == 56'd0), "end marker carries a pattern")
  `PRLD_ASSERT(a_copy_len, clk_i, rst_ni, (out_valid_o && !end_of_message_o) |-> (pattern_length_o != 4'd0), "copy with empty pattern")
  `PRLD_ASSERT(a_short_high, clk_i, rst_ni, (out_valid_o && !end_of_message_o && pattern_length_o <= 4'd8) |-> (pattern_high_o == 56'd0), "unused pattern bytes not zero")

endmodule

bind pattern_run_length_decoder_core prld_checker u_prld_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .pattern_low_o    (pattern_low_o),
  .pattern_high_o   (pattern_high_o),
  .pattern_length_o (pattern_length_o),
  .last_copy_o      (last_copy_o),
  .end_of_message_o (end_of_message_o)
);

`default_nettype wire
